// ----- rtl/core/dkd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkd_pkg
// Shared types, widths and codes of the delta keyframe decoder.
// ----------------------------------------------------------------------------
package dkd_pkg;

  localparam int VALUE_BYTES_DEF  = 8;
  localparam int LENGTH_BYTES_DEF = 4;

  localparam int VALUE_W  = 64;
  localparam int INDEX_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 32;
  localparam int POS_W    = 4;
  localparam int PADDR_W  = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;

  localparam logic REG_KF_COUNT = 1'b0;
  localparam logic REG_PERIOD   = 1'b1;

  typedef struct packed {
    logic               drop;
    logic [VALUE_W-1:0] diff;
  } dkd_rec_t;

endpackage
`default_nettype wire

// ----- rtl/core/delta_keyframe_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// delta_keyframe_decoder_unit
// Delta decoder with keyframes: turns a byte stream of length-prefixed
// records into absolute values with their record index and a status.
//
// Input channel in_valid/in_stall/in_byte takes one byte per cycle while
// in_stall is low; in_stall rises only when the two-entry record queue is
// full. Output channel out_valid/out_stall carries value, record_index and
// status, one word per completed or dropped record. A record is queued with
// its last byte, its result then registered at the output. With out_stall
// low, the rate is one byte per cycle, set by the parser taking one byte a
// cycle and the value unit finishing one record a cycle. A stalled word
// holds; the queue absorbs two more records before in_stall rises.
// Registers on the APB port: keyframe_count at 0x0, keyframe_period at
// 0x4; write them only while no record is in flight. Synchronous reset
// clears the registers, the parser, the queue, the previous value, the
// record count and the period phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
module delta_keyframe_decoder_unit
  import dkd_pkg::*;
#(
  parameter int VALUE_BYTES  = VALUE_BYTES_DEF,
  parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [CFG_W-1:0]     pwdata,
  output logic [CFG_W-1:0]          prdata,
  output logic                      pready,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [VALUE_W-1:0]        value,
  output logic [INDEX_W-1:0]        record_index,
  output logic [STATUS_W-1:0]       status
);

  logic [CFG_W-1:0] keyframe_count;
  logic [CFG_W-1:0] keyframe_period;
  logic             cfg_write;
  logic             q_full;
  logic             push;
  dkd_rec_t         push_rec;
  logic             q_valid;
  dkd_rec_t         q_rec;
  logic             pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_KF_COUNT: prdata = keyframe_count;
      REG_PERIOD:   prdata = keyframe_period;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keyframe_count  <= '0;
      keyframe_period <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_KF_COUNT) keyframe_count <= pwdata;
      else keyframe_period <= pwdata;
    end
  end

  dkd_front #(
    .VALUE_BYTES  (VALUE_BYTES),
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  dkd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_rec    (q_rec),
    .pop      (pop)
  );

  dkd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_rec           (q_rec),
    .pop             (pop),
    .keyframe_count  (keyframe_count),
    .keyframe_period (keyframe_period),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .value           (value),
    .record_index    (record_index),
    .status          (status)
  );

endmodule
`default_nettype wire

// ----- rtl/core/dkd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkd_front
// Byte parser: gathers the length and difference bytes of each record and
// pushes one finished or dropped record into the queue.
// ----------------------------------------------------------------------------
module dkd_front
  import dkd_pkg::*;
#(
  parameter int VALUE_BYTES  = VALUE_BYTES_DEF,
  parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_full,
  output logic            push,
  output dkd_rec_t        push_rec
);

  localparam int LEN_W  = 8 * LENGTH_BYTES;
  localparam int DIFF_W = 8 * VALUE_BYTES;

  logic              in_payload, in_payload_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [LEN_W-1:0]  record_length, record_length_next;
  logic [DIFF_W-1:0] diff_accum, diff_accum_next;
  logic [POS_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  len_lane;
  logic [DIFF_W-1:0] diff_lane;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pos_inc  = byte_position + POS_W'(1);

  always_comb begin
    len_lane = record_length;
    for (int i = 0; i < LENGTH_BYTES; i++) begin
      if (byte_position == POS_W'(i)) len_lane[8*i +: 8] = in_byte;
    end
    diff_lane = diff_accum;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      if (byte_position == POS_W'(i)) diff_lane[8*i +: 8] = in_byte;
    end
  end

  always_comb begin
    in_payload_next    = in_payload;
    byte_position_next = byte_position;
    record_length_next = record_length;
    diff_accum_next    = diff_accum;
    push               = 1'b0;
    push_rec           = '0;
    if (accept) begin
      if (!in_payload) begin
        if (pos_inc >= POS_W'(LENGTH_BYTES)) begin
          byte_position_next = '0;
          record_length_next = '0;
          if (len_lane > LEN_W'(VALUE_BYTES)) begin
            push          = 1'b1;
            push_rec.drop = 1'b1;
          end else if (len_lane == '0) begin
            push = 1'b1;
          end else begin
            in_payload_next    = 1'b1;
            record_length_next = len_lane;
            diff_accum_next    = '0;
          end
        end else begin
          byte_position_next = pos_inc;
          record_length_next = len_lane;
        end
      end else begin
        if (LEN_W'(pos_inc) >= record_length) begin
          push               = 1'b1;
          push_rec.diff      = VALUE_W'(diff_lane);
          in_payload_next    = 1'b0;
          byte_position_next = '0;
          record_length_next = '0;
        end else begin
          byte_position_next = pos_inc;
          diff_accum_next    = diff_lane;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      byte_position <= '0;
      record_length <= '0;
    end else begin
      in_payload    <= in_payload_next;
      byte_position <= byte_position_next;
      record_length <= record_length_next;
    end
    diff_accum <= diff_accum_next;
  end

endmodule
`default_nettype wire

// ----- rtl/core/dkd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkd_queue
// Short register queue of parsed records between the parser and the
// value unit.
// ----------------------------------------------------------------------------
module dkd_queue
  import dkd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire dkd_rec_t push_rec,
  output logic          full,
  output logic          q_valid,
  output dkd_rec_t      q_rec,
  input  wire logic     pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dkd_rec_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_rec   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
    if (push) entries[wr_ptr] <= push_rec;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("record pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("record popped from an empty queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/dkd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dkd_back
// Value unit: applies keyframe or delta rule, tracks record count and
// period phase, holds the result word until taken.
// ----------------------------------------------------------------------------
module dkd_back
  import dkd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire dkd_rec_t            q_rec,
  output logic                     pop,
  input  wire logic [CFG_W-1:0]    keyframe_count,
  input  wire logic [CFG_W-1:0]    keyframe_period,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [VALUE_W-1:0]       value,
  output logic [INDEX_W-1:0]       record_index,
  output logic [STATUS_W-1:0]      status
);

  logic [VALUE_W-1:0] previous_value;
  logic [INDEX_W-1:0] records_done;
  logic [CFG_W-1:0]   period_phase;
  logic [CFG_W:0]     phase_inc;
  logic               keyframe;
  logic [VALUE_W-1:0] decoded;

  assign pop       = q_valid && (!out_valid || !out_stall);
  assign keyframe  = (keyframe_count != '0) && (keyframe_period != '0) &&
                     (period_phase == '0);
  assign decoded   = keyframe ? q_rec.diff : previous_value + q_rec.diff;
  assign phase_inc = {1'b0, period_phase} + (CFG_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      previous_value <= '0;
      records_done   <= '0;
      period_phase   <= '0;
    end else begin
      out_valid <= pop || (out_valid && out_stall);
      if (pop) begin
        if (!q_rec.drop) begin
          previous_value <= decoded;
          records_done   <= records_done + INDEX_W'(1);
          period_phase   <= (phase_inc >= {1'b0, keyframe_period}) ? '0
                                                                   : phase_inc[CFG_W-1:0];
        end
      end
    end
    if (pop) begin
      record_index <= records_done;
      if (q_rec.drop) begin
        value  <= '0;
        status <= ST_DROP;
      end else begin
        value  <= decoded;
        status <= ((records_done != '0) && (q_rec.diff == '0)) ? ST_ZERO : ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_drop_holds_count: assert property (@(posedge clk) disable iff (rst)
    (pop && q_rec.drop) |=> (records_done == $past(records_done)))
    else $error("dropped record advanced the record count");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_ZERO || status == ST_DROP))
    else $error("result word carries an unknown status");
`endif

endmodule
`default_nettype wire
